### hw/rtl/elrdp_pkg.sv
package elrdp_pkg;

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_READ  = 1'b1;

    localparam logic [2:0] EVT_IDLE   = 3'd0;
    localparam logic [2:0] EVT_TIME   = 3'd1;
    localparam logic [2:0] EVT_ONOFF  = 3'd2;
    localparam logic [2:0] EVT_BRIGHT = 3'd3;
    localparam logic [2:0] EVT_BDELTA = 3'd4;

    localparam logic       REG_MIN_VALID_TIME = 1'b0;
    localparam logic       REG_TIME_ZONE      = 1'b1;

    localparam logic [31:0] MIN_VALID_TIME_RESET = 32'd94867200;
    localparam logic [7:0]  TIME_ZONE_RESET      = 8'd0;

    localparam logic [31:0] GAP_LIMIT   = 32'h0000_3FFF;
    localparam logic [31:0] MINUTES_MAX = 32'h0FFF_FFFE;
    localparam logic [31:0] BRIGHT_MAX  = 32'd100;
    localparam logic [4:0]  TZ_BYTES    = 5'd10;

    typedef struct packed {
        logic        is_read;
        logic [2:0]  event_type;
        logic [31:0] event_value;
        logic [31:0] now;
        logic [26:0] now_min;
        logic        first;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  rtype;
        logic [31:0] lasttime;
        logic [15:0] delta;
        logic [31:0] value;
    } rec_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_W_LOOK,
        B_W_LMIN,
        B_W_GAP,
        B_W_EVENT,
        B_R_START,
        B_R_MIN,
        B_R_PCT,
        B_R_EMPTY,
        B_R_EMIT
    } back_state_t;

    // x / 60 as (x >> 2) / 15 by reciprocal multiply
    function automatic logic [26:0] div60(input logic [31:0] x);
        logic [61:0] prod;
        prod = 62'(x[31:2]) * 62'(32'h8888_8889);
        return prod[61:35];
    endfunction

    // x / 100 as (x >> 2) / 25 by reciprocal multiply, exact for 16-bit x
    function automatic logic [9:0] div100(input logic [15:0] x);
        logic [28:0] prod;
        prod = 29'(x[15:2]) * 29'(15'd20972);
        return prod[28:19];
    endfunction

endpackage

### hw/rtl/event_log_ring_delta_packer_top.sv
// event log ring with minute-delta records and byte-packed readout
// input channel (in_valid/in_ready): mode 0 logs an event, mode 1 reads the
// oldest record. a write gives no output transfer; a read gives 1 to 14
// output transfers (out_valid/out_ready), the final one flagged by last.
// an empty log or a record with no bytes and no header gives one transfer
// with has_byte low. remaining is the record count left after the read.
// timing: an accepted item passes through the input stage register and the
// two-entry command queue; the back end sequencer then stores a time write
// from its lookup state, reads the newest record, takes its minute and checks
// the gap before storing an event write, and on a read starts, takes the
// minute and percentage, then sends the output transfers (an empty log skips to its single transfer).
// a stalled receiver holds the output register; the queue keeps accepting
// until full, then in_ready drops.
// after reset the record memory is swept to zero with in_ready low; config
// writes (cfg_write, cfg_index, cfg_data) are taken at any time but only make
// sense while the block is idle.
module event_log_ring_delta_packer_top #(
    parameter int LOG_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [2:0]  event_type,
    input  logic [31:0] event_value,
    input  logic [31:0] now_seconds,
    input  logic        suppress,
    input  logic        first_in_batch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic        last,
    output logic [7:0]  remaining,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] min_valid_time_reg, min_valid_time_next;
    logic [7:0]  time_zone_reg, time_zone_next;

    elrdp_pkg::back_status_t status;
    elrdp_pkg::cmd_t         push_cmd;
    elrdp_pkg::cmd_t         pop_cmd;
    logic                    push;
    logic                    pop;
    logic                    fifo_full;
    logic                    fifo_empty;

    always_comb
    begin
        min_valid_time_next = min_valid_time_reg;
        time_zone_next      = time_zone_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                elrdp_pkg::REG_MIN_VALID_TIME: min_valid_time_next = cfg_data;
                elrdp_pkg::REG_TIME_ZONE:      time_zone_next      = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_time_reg <= elrdp_pkg::MIN_VALID_TIME_RESET;
            time_zone_reg      <= elrdp_pkg::TIME_ZONE_RESET;
        end
        else
        begin
            min_valid_time_reg <= min_valid_time_next;
            time_zone_reg      <= time_zone_next;
        end
    end

    elrdp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .event_type     (event_type),
        .event_value    (event_value),
        .now_seconds    (now_seconds),
        .suppress       (suppress),
        .first_in_batch (first_in_batch),
        .min_valid_time (min_valid_time_reg),
        .status         (status),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    elrdp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    elrdp_back #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .cmd        (pop_cmd),
        .pop        (pop),
        .time_zone  (time_zone_reg),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .last       (last),
        .remaining  (remaining)
    );

endmodule

### hw/rtl/elrdp_cmd_fifo.sv
module elrdp_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  elrdp_pkg::cmd_t    push_cmd,
    output logic               full,
    input  logic               pop,
    output elrdp_pkg::cmd_t    pop_cmd,
    output logic               empty
);

    elrdp_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/elrdp_front.sv
module elrdp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    mode,
    input  logic [2:0]              event_type,
    input  logic [31:0]             event_value,
    input  logic [31:0]             now_seconds,
    input  logic                    suppress,
    input  logic                    first_in_batch,
    input  logic [31:0]             min_valid_time,
    input  elrdp_pkg::back_status_t status,
    input  logic                    fifo_full,
    output logic                    push,
    output elrdp_pkg::cmd_t         push_cmd
);

    logic        stg_valid_reg, stg_valid_next;
    logic        stg_mode_reg;
    logic [2:0]  stg_type_reg;
    logic [31:0] stg_value_reg;
    logic [31:0] stg_now_reg;
    logic        stg_first_reg;
    logic        drop;
    logic        take;

    // writes that store nothing are swallowed here
    assign drop = (mode == elrdp_pkg::MODE_WRITE) &&
                  (suppress || (event_type == elrdp_pkg::EVT_IDLE) ||
                   (now_seconds < min_valid_time));

    assign in_ready = !status.clearing && (!stg_valid_reg || !fifo_full);
    assign take     = in_valid && in_ready;
    assign push     = stg_valid_reg && !fifo_full;

    always_comb
    begin
        push_cmd.is_read     = (stg_mode_reg == elrdp_pkg::MODE_READ);
        push_cmd.event_type  = stg_type_reg;
        push_cmd.event_value = stg_value_reg;
        push_cmd.now         = stg_now_reg;
        push_cmd.now_min     = elrdp_pkg::div60(stg_now_reg);
        push_cmd.first       = stg_first_reg;
    end

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (take && !drop)
        begin
            stg_valid_next = 1'b1;
        end
        else if (push)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !drop)
        begin
            stg_mode_reg  <= mode;
            stg_type_reg  <= event_type;
            stg_value_reg <= event_value;
            stg_now_reg   <= now_seconds;
            stg_first_reg <= first_in_batch;
        end
    end

endmodule

### hw/rtl/elrdp_back.sv
module elrdp_back #(
    parameter int LOG_DEPTH = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fifo_empty,
    input  elrdp_pkg::cmd_t         cmd,
    output logic                    pop,
    input  logic [7:0]              time_zone,
    output elrdp_pkg::back_status_t status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    has_byte,
    output logic                    last,
    output logic [7:0]              remaining
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(LOG_DEPTH);

    elrdp_pkg::back_state_t state_reg, state_next;
    elrdp_pkg::cmd_t        cmd_reg, cmd_next;
    elrdp_pkg::rec_t        mem [LOG_DEPTH];
    elrdp_pkg::rec_t        rd_reg;
    elrdp_pkg::rec_t        mem_wdata;

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [26:0]   last_min_reg, last_min_next;
    logic [31:0]   ev_last_reg, ev_last_next;
    logic [15:0]   ev_delta_reg, ev_delta_next;
    logic [27:0]   minutes_reg, minutes_next;
    logic [5:0]    pct_reg, pct_next;
    logic          hdr_reg, hdr_next;
    logic [4:0]    n_reg, n_next;
    logic [4:0]    k_reg, k_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          has_byte_reg, has_byte_next;
    logic          last_reg, last_next;
    logic [7:0]    rem_reg, rem_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] wp_inc;
    logic [AW-1:0] wp_prev;
    logic [AW-1:0] rd_start;
    logic [CW-1:0] count_inc;
    logic [31:0]   gap;
    logic [26:0]   src_min;
    logic [9:0]    pct_full;
    logic [4:0]    body_len;
    logic          out_free;
    logic          k_last;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_ADDR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [7:0] tz_byte(input logic [3:0] idx, input logic [27:0] m,
                                           input logic [7:0] z);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h03;
            4'd2:    b = {4'hE, m[27:24]};
            4'd3:    b = m[23:16];
            4'd4:    b = m[15:8];
            4'd5:    b = m[7:0];
            4'd6:    b = 8'h00;
            4'd7:    b = 8'h03;
            4'd8:    b = {6'b111110, z[7:6]};
            4'd9:    b = {z[5:0], 2'b00};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] body_byte(input logic [3:0] idx, input elrdp_pkg::rec_t r,
                                             input logic [5:0] pct);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0:
            begin
                b = r.delta[13:6];
            end
            4'd1:
            begin
                case (r.rtype)
                    elrdp_pkg::EVT_ONOFF:  b = {r.delta[5:0], 1'b0, r.value[17]};
                    elrdp_pkg::EVT_BRIGHT: b = {r.delta[5:0], 2'b10};
                    default:               b = {r.delta[5:0], 2'b11};
                endcase
            end
            4'd2:
            begin
                case (r.rtype)
                    elrdp_pkg::EVT_ONOFF:  b = {r.value[16], r.value[6:0]};
                    elrdp_pkg::EVT_BRIGHT:
                        b = (r.value > elrdp_pkg::BRIGHT_MAX) ?
                            elrdp_pkg::BRIGHT_MAX[7:0] : r.value[7:0];
                    default:               b = {2'b00, r.value[23:18]};
                endcase
            end
            4'd3:
            begin
                b = {r.value[17:16], 6'b0} + {2'b00, pct};
            end
            default:
            begin
                b = 8'h00;
            end
        endcase
        return b;
    endfunction

    assign wp_inc    = ptr_inc(wp_reg);
    assign wp_prev   = (wp_reg == '0) ? LAST_ADDR : wp_reg - 1'b1;
    assign rd_start  = (count_reg >= FULL_COUNT) ? wp_reg : rp_reg;
    assign count_inc = (count_reg == FULL_COUNT) ? count_reg : count_reg + 1'b1;
    assign gap       = 32'(cmd_reg.now_min) - 32'(last_min_reg);
    assign src_min   = elrdp_pkg::div60((rd_reg.rtype == elrdp_pkg::EVT_TIME) ?
                                        rd_reg.value : rd_reg.lasttime);
    assign pct_full  = elrdp_pkg::div100(rd_reg.value[15:0]);
    assign out_free  = !out_valid_reg || out_ready;
    assign k_last    = (k_reg == n_reg - 5'd1);

    always_comb
    begin
        case (rd_reg.rtype)
            elrdp_pkg::EVT_TIME:   body_len = elrdp_pkg::TZ_BYTES;
            elrdp_pkg::EVT_ONOFF:  body_len = 5'd3;
            elrdp_pkg::EVT_BRIGHT: body_len = 5'd3;
            elrdp_pkg::EVT_BDELTA: body_len = 5'd4;
            default:               body_len = 5'd0;
        endcase
    end

    assign status.clearing = (state_reg == elrdp_pkg::B_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign has_byte  = has_byte_reg;
    assign last      = last_reg;
    assign remaining = rem_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            elrdp_pkg::B_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = elrdp_pkg::B_IDLE;
                end
            end
            elrdp_pkg::B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = cmd.is_read ? elrdp_pkg::B_R_START : elrdp_pkg::B_W_LOOK;
                end
            end
            elrdp_pkg::B_W_LOOK:
            begin
                state_next = (cmd_reg.event_type == elrdp_pkg::EVT_TIME) ?
                             elrdp_pkg::B_IDLE : elrdp_pkg::B_W_LMIN;
            end
            elrdp_pkg::B_W_LMIN:  state_next = elrdp_pkg::B_W_GAP;
            elrdp_pkg::B_W_GAP:   state_next = elrdp_pkg::B_W_EVENT;
            elrdp_pkg::B_W_EVENT: state_next = elrdp_pkg::B_IDLE;
            elrdp_pkg::B_R_START:
            begin
                state_next = (count_reg == '0) ? elrdp_pkg::B_R_EMPTY : elrdp_pkg::B_R_MIN;
            end
            elrdp_pkg::B_R_MIN:   state_next = elrdp_pkg::B_R_PCT;
            elrdp_pkg::B_R_PCT:
            begin
                state_next = (n_reg == 5'd0) ? elrdp_pkg::B_R_EMPTY : elrdp_pkg::B_R_EMIT;
            end
            elrdp_pkg::B_R_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = elrdp_pkg::B_IDLE;
                end
            end
            elrdp_pkg::B_R_EMIT:
            begin
                if (out_free && k_last)
                begin
                    state_next = elrdp_pkg::B_IDLE;
                end
            end
            default:              state_next = elrdp_pkg::B_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd_next       = cmd_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        last_min_next  = last_min_reg;
        ev_last_next   = ev_last_reg;
        ev_delta_next  = ev_delta_reg;
        minutes_next   = minutes_reg;
        pct_next       = pct_reg;
        hdr_next       = hdr_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        has_byte_next  = has_byte_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = wp_prev;
        case (state_reg)
            elrdp_pkg::B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            elrdp_pkg::B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = cmd;
                end
            end
            elrdp_pkg::B_W_LOOK:
            begin
                if (cmd_reg.event_type == elrdp_pkg::EVT_TIME)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{elrdp_pkg::EVT_TIME, cmd_reg.now, 16'd0, cmd_reg.now};
                    wp_next    = wp_inc;
                    count_next = count_inc;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = wp_prev;
                end
            end
            elrdp_pkg::B_W_LMIN:
            begin
                last_min_next = elrdp_pkg::div60(rd_reg.lasttime);
            end
            elrdp_pkg::B_W_GAP:
            begin
                // a long gap gets an absolute time record in front of the event
                if (gap > elrdp_pkg::GAP_LIMIT)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = '{elrdp_pkg::EVT_TIME, cmd_reg.now, 16'd0, cmd_reg.now};
                    wp_next       = wp_inc;
                    count_next    = count_inc;
                    ev_last_next  = cmd_reg.now;
                    ev_delta_next = 16'd0;
                end
                else
                begin
                    ev_last_next  = rd_reg.lasttime;
                    ev_delta_next = gap[15:0];
                end
            end
            elrdp_pkg::B_W_EVENT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '{cmd_reg.event_type, ev_last_reg, ev_delta_reg,
                               cmd_reg.event_value};
                wp_next    = wp_inc;
                count_next = count_inc;
            end
            elrdp_pkg::B_R_START:
            begin
                if (count_reg != '0)
                begin
                    rp_next   = rd_start;
                    mem_re    = 1'b1;
                    mem_raddr = rd_start;
                end
            end
            elrdp_pkg::B_R_MIN:
            begin
                minutes_next = (32'(src_min) > elrdp_pkg::MINUTES_MAX) ?
                               elrdp_pkg::MINUTES_MAX[27:0] : 28'(src_min);
                hdr_next     = cmd_reg.first && (rd_reg.rtype != elrdp_pkg::EVT_TIME);
                n_next       = ((cmd_reg.first && (rd_reg.rtype != elrdp_pkg::EVT_TIME)) ?
                                elrdp_pkg::TZ_BYTES : 5'd0) + body_len;
            end
            elrdp_pkg::B_R_PCT:
            begin
                pct_next   = pct_full[5:0];
                count_next = count_reg - 1'b1;
                k_next     = 5'd0;
                // log emptied: both pointers go back to the start
                if (count_reg == CW'(1))
                begin
                    rp_next = '0;
                    wp_next = '0;
                end
                else
                begin
                    rp_next = ptr_inc(rp_reg);
                end
            end
            elrdp_pkg::B_R_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'h00;
                    has_byte_next  = 1'b0;
                    last_next      = 1'b1;
                    rem_next       = 8'(count_reg);
                end
            end
            elrdp_pkg::B_R_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    has_byte_next  = 1'b1;
                    last_next      = k_last;
                    rem_next       = 8'(count_reg);
                    k_next         = k_reg + 5'd1;
                    if (hdr_reg && (k_reg < elrdp_pkg::TZ_BYTES))
                    begin
                        out_byte_next = tz_byte(k_reg[3:0], minutes_reg, time_zone);
                    end
                    else if (rd_reg.rtype == elrdp_pkg::EVT_TIME)
                    begin
                        out_byte_next = tz_byte(k_reg[3:0], minutes_reg, time_zone);
                    end
                    else
                    begin
                        out_byte_next = body_byte(hdr_reg ?
                                                  4'(k_reg - elrdp_pkg::TZ_BYTES) :
                                                  k_reg[3:0], rd_reg, pct_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= elrdp_pkg::B_CLEAR;
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        last_min_reg <= last_min_next;
        ev_last_reg  <= ev_last_next;
        ev_delta_reg <= ev_delta_next;
        minutes_reg  <= minutes_next;
        pct_reg      <= pct_next;
        hdr_reg      <= hdr_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        out_byte_reg <= out_byte_next;
        has_byte_reg <= has_byte_next;
        last_reg     <= last_next;
        rem_reg      <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

endmodule
